// ===== hdl/lfr_pkg.sv =====
// shared types and constants of the link frame receiver
package lfr_pkg;

  // bytes with a fixed meaning on the link
  localparam logic [7:0] StartByte   = 8'h3D;
  localparam logic [7:0] ConfirmByte = 8'hC5;

  // payload bytes of the head-unit commands
  localparam logic [7:0] OpVersion   = 8'h31;
  localparam logic [7:0] OpPlay      = 8'h13;
  localparam logic [7:0] OpPause     = 8'h1C;
  localparam logic [7:0] OpStandby   = 8'h19;
  localparam logic [7:0] OpDisc      = 8'h24;
  localparam logic [7:0] OpNext      = 8'h17;
  localparam logic [7:0] OpPrev      = 8'h22;
  localparam logic [7:0] OpEnterExit = 8'h2C;
  localparam logic [7:0] ArgOne      = 8'h01;
  localparam logic [7:0] ArgTwo      = 8'h02;
  localparam logic [7:0] ArgEnter    = 8'hFF;
  localparam logic [7:0] ArgExit     = 8'h00;

  // payload lengths of the commands
  localparam logic [7:0] LenVersion = 8'd7;
  localparam logic [7:0] LenOne     = 8'd1;
  localparam logic [7:0] LenTwo     = 8'd2;
  localparam logic [7:0] LenThree   = 8'd3;

  // header and checksum bytes around the payload
  localparam int unsigned FrameOverhead = 4;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_CONFIRM = 3'd1,
    EV_GOOD    = 3'd2,
    EV_BAD_SUM = 3'd3,
    EV_DROPPED = 3'd4
  } frame_event_e;

  typedef enum logic [3:0] {
    CMD_NONE    = 4'd0,
    CMD_VERSION = 4'd1,
    CMD_PLAY    = 4'd2,
    CMD_PAUSE   = 4'd3,
    CMD_STANDBY = 4'd4,
    CMD_DISC    = 4'd5,
    CMD_NEXT    = 4'd6,
    CMD_PREV    = 4'd7,
    CMD_ENTER   = 4'd8,
    CMD_EXIT    = 4'd9
  } command_e;

  typedef struct packed {
    frame_event_e frame_event;
    command_e     command;
    logic [7:0]   frame_sequence;
    logic [7:0]   frame_length;
  } result_t;

endpackage

// ===== hdl/lfr_if.sv =====
// valid/ready channels for received bytes and frame results

interface lfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface lfr_event_if;
  logic       valid;
  logic       ready;
  logic [2:0] frame_event;
  logic [3:0] command;
  logic [7:0] frame_sequence;
  logic [7:0] frame_length;

  modport source (output valid, output frame_event, output command,
                  output frame_sequence, output frame_length, input ready);
  modport sink (input valid, input frame_event, input command,
                input frame_sequence, input frame_length, output ready);
endinterface

// ===== hdl/link_frame_receiver_core.sv =====
// top level of the link frame receiver: input register, frame engine, result register
//
// Receive side of a head-unit serial link. Each beat on rx_i carries one
// received byte; each accepted byte yields exactly one beat on ev_o with
// the frame event, the decoded command and, on a completed frame, its
// sequence and length bytes.
// An accepted byte is held in the input register and then in the result
// register, from which its result shows on ev_o.
// Throughput: one byte per cycle while ev_o takes results. The input register and the result
// register form a two-stage pipeline; a byte is taken while a result
// still waits on ev_o, as long as the input register can move on.
// Stall: when ev_o is held off and both stages are full, rx_i.ready drops
// in the same cycle and the pipeline holds; nothing is lost or repeated.
// Reset: rst_ni clears both stages and the frame state; the block then
// waits for a start or confirmation byte.
// MAX_FRAME_BYTES sets the byte count at which an unfinished frame is
// dropped and the width of the position counter.
module link_frame_receiver_core #(
  parameter int unsigned MAX_FRAME_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lfr_byte_if.sink    rx_i,
  lfr_event_if.source ev_o
);

  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             out_valid_q;
  lfr_pkg::result_t out_q;
  lfr_pkg::result_t result;
  logic             advance;
  logic             take_in;

  // pipeline control
  assign advance    = in_valid_q && (!out_valid_q || ev_o.ready);
  assign rx_i.ready = !in_valid_q || advance;
  assign take_in    = rx_i.valid && rx_i.ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  lfr_frame_engine #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .result_o (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (ev_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign ev_o.valid          = out_valid_q;
  assign ev_o.frame_event    = out_q.frame_event;
  assign ev_o.command        = out_q.command;
  assign ev_o.frame_sequence = out_q.frame_sequence;
  assign ev_o.frame_length   = out_q.frame_length;

endmodule

// ===== hdl/lfr_cmd_decode.sv =====
// head-unit command decode from payload length and first payload bytes
module lfr_cmd_decode (
  input  logic [7:0]        length_i,
  input  logic [7:0]        p0_i,
  input  logic [7:0]        p1_i,
  input  logic [7:0]        p2_i,
  output lfr_pkg::command_e command_o
);

  // first match wins, unknown combinations give no command
  always_comb begin
    command_o = lfr_pkg::CMD_NONE;
    if (length_i == lfr_pkg::LenVersion && p0_i == lfr_pkg::OpVersion) begin
      command_o = lfr_pkg::CMD_VERSION;
    end else if (length_i == lfr_pkg::LenOne) begin
      if (p0_i == lfr_pkg::OpPlay) begin
        command_o = lfr_pkg::CMD_PLAY;
      end else if (p0_i == lfr_pkg::OpPause) begin
        command_o = lfr_pkg::CMD_PAUSE;
      end else if (p0_i == lfr_pkg::OpStandby) begin
        command_o = lfr_pkg::CMD_STANDBY;
      end else if (p0_i == lfr_pkg::OpDisc) begin
        command_o = lfr_pkg::CMD_DISC;
      end
    end else if (length_i == lfr_pkg::LenTwo) begin
      if (p0_i == lfr_pkg::OpNext && p1_i == lfr_pkg::ArgOne) begin
        command_o = lfr_pkg::CMD_NEXT;
      end else if (p0_i == lfr_pkg::OpEnterExit && p1_i == lfr_pkg::ArgEnter) begin
        command_o = lfr_pkg::CMD_ENTER;
      end else if (p0_i == lfr_pkg::OpEnterExit && p1_i == lfr_pkg::ArgExit) begin
        command_o = lfr_pkg::CMD_EXIT;
      end
    end else if (length_i == lfr_pkg::LenThree && p0_i == lfr_pkg::OpPrev &&
                 p1_i == lfr_pkg::ArgOne && p2_i == lfr_pkg::ArgTwo) begin
      command_o = lfr_pkg::CMD_PREV;
    end
  end

endmodule

// ===== hdl/lfr_frame_engine.sv =====
// frame tracking state: position, running xor, header and payload head bytes
module lfr_frame_engine #(
  parameter int unsigned MAX_FRAME_BYTES = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  output lfr_pkg::result_t result_o
);

  localparam int unsigned PosW = $clog2(MAX_FRAME_BYTES);
  localparam int unsigned NxtW = PosW + 1;

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      xor_q, xor_d;
  logic [7:0]      len_q, len_d;
  logic [7:0]      seq_q, seq_d;
  logic [7:0]      head_q [3];
  logic [7:0]      head_d [3];

  logic [NxtW-1:0]       nxt;
  logic                  complete;
  lfr_pkg::frame_event_e ev;
  lfr_pkg::command_e     cmd;
  logic [7:0]            seq_out;
  logic [7:0]            len_out;

  // per-byte frame parsing
  always_comb begin
    pos_d    = pos_q;
    xor_d    = xor_q;
    len_d    = len_q;
    seq_d    = seq_q;
    head_d   = head_q;
    nxt      = '0;
    complete = 1'b0;
    ev       = lfr_pkg::EV_NONE;
    seq_out  = '0;
    len_out  = '0;
    if (pos_q == '0) begin
      if (byte_i == lfr_pkg::ConfirmByte) begin
        ev = lfr_pkg::EV_CONFIRM;
      end else if (byte_i == lfr_pkg::StartByte) begin
        xor_d = byte_i;
        pos_d = PosW'(1);
      end
    end else begin
      nxt = {1'b0, pos_q} + NxtW'(1);
      // capture header and first payload bytes
      if (pos_q == PosW'(1)) begin
        seq_d = byte_i;
      end else if (pos_q == PosW'(2)) begin
        len_d = byte_i;
      end else if (pos_q == PosW'(3)) begin
        head_d[0] = byte_i;
      end else if (pos_q == PosW'(4)) begin
        head_d[1] = byte_i;
      end else if (pos_q == PosW'(5)) begin
        head_d[2] = byte_i;
      end
      // checksum byte closes the frame
      complete = (nxt >= NxtW'(lfr_pkg::FrameOverhead)) &&
                 (9'(nxt) == ({1'b0, len_q} + 9'(lfr_pkg::FrameOverhead)));
      if (complete) begin
        ev      = (byte_i == xor_q) ? lfr_pkg::EV_GOOD : lfr_pkg::EV_BAD_SUM;
        seq_out = seq_q;
        len_out = len_q;
        nxt     = '0;
      end else begin
        xor_d = xor_q ^ byte_i;
      end
      // frame grew to the byte limit without closing
      if (nxt >= NxtW'(MAX_FRAME_BYTES)) begin
        nxt = '0;
        ev  = lfr_pkg::EV_DROPPED;
      end
      pos_d = nxt[PosW-1:0];
    end
  end

  lfr_cmd_decode u_decode (
    .length_i  (len_q),
    .p0_i      (head_d[0]),
    .p1_i      (head_d[1]),
    .p2_i      (head_d[2]),
    .command_o (cmd)
  );

  // result of this byte
  always_comb begin
    result_o.frame_event    = ev;
    result_o.command        = (ev == lfr_pkg::EV_GOOD) ? cmd : lfr_pkg::CMD_NONE;
    result_o.frame_sequence = seq_out;
    result_o.frame_length   = len_out;
  end

  // state update on each processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      xor_q  <= '0;
      len_q  <= '0;
      seq_q  <= '0;
      head_q <= '{default: '0};
    end else if (step_i) begin
      pos_q  <= pos_d;
      xor_q  <= xor_d;
      len_q  <= len_d;
      seq_q  <= seq_d;
      head_q <= head_d;
    end
  end

endmodule

// ===== hdl/lfr_checker.sv =====
// port-level checks of the link frame receiver, bound to the top level
module lfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rx_valid_i,
  input logic       rx_ready_i,
  input logic       ev_valid_i,
  input logic       ev_ready_i,
  input logic [2:0] frame_event_i,
  input logic [3:0] command_i,
  input logic [7:0] frame_sequence_i,
  input logic [7:0] frame_length_i
);

  logic good_or_bad;
  assign good_or_bad = (frame_event_i == lfr_pkg::EV_GOOD) ||
                       (frame_event_i == lfr_pkg::EV_BAD_SUM);

  // a held result beat keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_i && !ev_ready_i |=> ev_valid_i && $stable(frame_event_i) &&
    $stable(command_i) && $stable(frame_sequence_i) && $stable(frame_length_i))
    else $error("result beat changed while stalled");

  // input only backs off when the result side is stalled
  a_no_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_ready_i |-> ev_valid_i && !ev_ready_i)
    else $error("input stalled without output back-pressure");

  // header bytes only reported on a completed frame
  a_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_i && !good_or_bad |-> frame_sequence_i == 8'd0 && frame_length_i == 8'd0)
    else $error("header bytes reported outside a completed frame");

  // a command only comes with a good frame
  a_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_i && command_i != lfr_pkg::CMD_NONE |-> frame_event_i == lfr_pkg::EV_GOOD)
    else $error("command reported without a good frame");

  // an idle output gets no new result without an accepted byte
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rx_valid_i && rx_ready_i) && !ev_valid_i ##1
    !(rx_valid_i && rx_ready_i) && !ev_valid_i
    |=> !ev_valid_i)
    else $error("result beat without an accepted byte");

endmodule

bind link_frame_receiver_core lfr_checker u_lfr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .rx_valid_i       (rx_i.valid),
  .rx_ready_i       (rx_i.ready),
  .ev_valid_i       (ev_o.valid),
  .ev_ready_i       (ev_o.ready),
  .frame_event_i    (ev_o.frame_event),
  .command_i        (ev_o.command),
  .frame_sequence_i (ev_o.frame_sequence),
  .frame_length_i   (ev_o.frame_length)
);

// ===== test/tb.sv =====
// self-checking testbench for link_frame_receiver_core
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FrameLimit  = 32;
  localparam int          ByteTarget  = 1950;
  localparam int          LongHold    = 250;
  localparam int          QuietLimit  = 5000;
  localparam int          TailCycles  = 8;

  typedef struct {
    logic [7:0] data;
    int         gap_after;
    bit         drain;
  } rx_item_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  // signals driven into the channels
  logic       byte_valid   = 1'b0;
  logic [7:0] byte_data    = 8'h00;
  logic       result_ready = 1'b0;

  lfr_byte_if  rx_ch ();
  lfr_event_if ev_ch ();

  assign rx_ch.valid   = byte_valid;
  assign rx_ch.rx_byte = byte_data;
  assign ev_ch.ready   = result_ready;

  link_frame_receiver_core #(
    .MAX_FRAME_BYTES(FrameLimit)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_ch),
    .ev_o  (ev_ch)
  );

  // clock, period 8 ns
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // bytes waiting to be sent and results waiting to come out
  rx_item_t          byte_backlog [$];
  lfr_pkg::result_t  pending_results [$];

  // shadow of the frame state
  int         frame_pos;
  logic [7:0] sum_acc;
  logic [7:0] len_hdr;
  logic [7:0] seq_hdr;
  logic [7:0] head_bytes [3];

  // run bookkeeping
  int  bytes_queued;
  int  bytes_sent;
  int  results_seen;
  int  mismatches;
  int  event_tally [5];
  int  command_tally [10];
  bit  long_hold_done;
  bit  drain_next;
  int  quiet_cycles;

  logic [7:0] op_bytes [8] = '{lfr_pkg::OpVersion, lfr_pkg::OpPlay, lfr_pkg::OpPause,
                               lfr_pkg::OpStandby, lfr_pkg::OpDisc, lfr_pkg::OpNext,
                               lfr_pkg::OpPrev, lfr_pkg::OpEnterExit};

  // command lookup of a good frame
  function automatic lfr_pkg::command_e decode_head_command();
    if (len_hdr == lfr_pkg::LenVersion && head_bytes[0] == lfr_pkg::OpVersion)
      return lfr_pkg::CMD_VERSION;
    if (len_hdr == lfr_pkg::LenOne) begin
      if (head_bytes[0] == lfr_pkg::OpPlay)    return lfr_pkg::CMD_PLAY;
      if (head_bytes[0] == lfr_pkg::OpPause)   return lfr_pkg::CMD_PAUSE;
      if (head_bytes[0] == lfr_pkg::OpStandby) return lfr_pkg::CMD_STANDBY;
      if (head_bytes[0] == lfr_pkg::OpDisc)    return lfr_pkg::CMD_DISC;
    end
    if (len_hdr == lfr_pkg::LenTwo) begin
      if (head_bytes[0] == lfr_pkg::OpNext && head_bytes[1] == lfr_pkg::ArgOne)
        return lfr_pkg::CMD_NEXT;
      if (head_bytes[0] == lfr_pkg::OpEnterExit && head_bytes[1] == lfr_pkg::ArgEnter)
        return lfr_pkg::CMD_ENTER;
      if (head_bytes[0] == lfr_pkg::OpEnterExit && head_bytes[1] == lfr_pkg::ArgExit)
        return lfr_pkg::CMD_EXIT;
    end
    if (len_hdr == lfr_pkg::LenThree && head_bytes[0] == lfr_pkg::OpPrev &&
        head_bytes[1] == lfr_pkg::ArgOne && head_bytes[2] == lfr_pkg::ArgTwo)
      return lfr_pkg::CMD_PREV;
    return lfr_pkg::CMD_NONE;
  endfunction

  // advance the frame state by one byte and return the result it causes
  function automatic lfr_pkg::result_t predict_frame_result(input logic [7:0] b);
    lfr_pkg::result_t r;
    int      pos;
    int      nxt;
    r.frame_event    = lfr_pkg::EV_NONE;
    r.command        = lfr_pkg::CMD_NONE;
    r.frame_sequence = 8'h00;
    r.frame_length   = 8'h00;
    pos = frame_pos;
    if (pos >= FrameLimit) pos = 0;
    if (pos == 0) begin
      if (b == lfr_pkg::ConfirmByte) begin
        r.frame_event = lfr_pkg::EV_CONFIRM;
      end else if (b == lfr_pkg::StartByte) begin
        sum_acc = b;
        pos = 1;
      end
    end else begin
      nxt = pos + 1;
      if (pos == 1) seq_hdr = b;
      else if (pos == 2) len_hdr = b;
      else if (pos <= 5) head_bytes[pos-3] = b;
      // last byte of the frame carries the checksum
      if (nxt >= lfr_pkg::FrameOverhead &&
          nxt == int'(len_hdr) + lfr_pkg::FrameOverhead) begin
        if (b == sum_acc) begin
          r.frame_event = lfr_pkg::EV_GOOD;
          r.command     = decode_head_command();
        end else begin
          r.frame_event = lfr_pkg::EV_BAD_SUM;
        end
        r.frame_sequence = seq_hdr;
        r.frame_length   = len_hdr;
        nxt = 0;
      end else begin
        sum_acc = sum_acc ^ b;
      end
      // overlong frame
      if (nxt >= FrameLimit) begin
        nxt = 0;
        r.frame_event = lfr_pkg::EV_DROPPED;
      end
      pos = nxt;
    end
    frame_pos = pos;
    return r;
  endfunction

  // idle cycles after a byte: none in calm stretches, else mostly short
  function automatic int next_gap();
    int roll;
    if ((bytes_queued / 150) % 4 == 3) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_byte(input logic [7:0] b);
    rx_item_t item;
    item.data      = b;
    item.gap_after = next_gap();
    item.drain     = drain_next;
    byte_backlog.push_back(item);
    drain_next = 1'b0;
    bytes_queued++;
  endtask

  // queue a whole frame; overlong ones are cut a little past the drop point
  task automatic send_frame(input logic [7:0] frame_seq, input int len,
                            input logic [7:0] p0, input logic [7:0] p1,
                            input logic [7:0] p2, input bit bad_sum);
    logic [7:0] sum;
    logic [7:0] b;
    int         total;
    total = len + lfr_pkg::FrameOverhead;
    if (total > FrameLimit) total = FrameLimit + $urandom_range(0, 3);
    sum = 8'h00;
    for (int i = 0; i < total; i++) begin
      if (i == 0) b = lfr_pkg::StartByte;
      else if (i == 1) b = frame_seq;
      else if (i == 2) b = len[7:0];
      else if (i == len + 3) b = bad_sum ? (sum ^ 8'($urandom_range(1, 255))) : sum;
      else if (i == 3) b = p0;
      else if (i == 4) b = p1;
      else if (i == 5) b = p2;
      else b = 8'($urandom);
      sum = sum ^ b;
      push_byte(b);
    end
  endtask

  // byte side: offer queued bytes, predict on every accepted beat
  rx_item_t next_item;
  int       gap_left;
  int       cur_gap;
  int       gap_now;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid <= 1'b0;
      byte_data  <= 8'h00;
      gap_left   <= 0;
      cur_gap    <= 0;
    end else begin
      if (byte_valid && rx_ch.ready) begin
        pending_results.push_back(predict_frame_result(byte_data));
        bytes_sent++;
      end
      if (!byte_valid || rx_ch.ready) begin
        gap_now = byte_valid ? cur_gap : gap_left;
        if (gap_now > 0) begin
          gap_left   <= gap_now - 1;
          byte_valid <= 1'b0;
        end else if (byte_backlog.size() > 0 &&
                     !(byte_backlog[0].drain && pending_results.size() > 0)) begin
          next_item  = byte_backlog.pop_front();
          byte_data  <= next_item.data;
          cur_gap    <= next_item.gap_after;
          gap_left   <= 0;
          byte_valid <= 1'b1;
        end else begin
          gap_left   <= 0;
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // result side: compare each beat with the oldest prediction, stall at random
  lfr_pkg::result_t want;
  int      hold_left;
  int      roll;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_ready <= 1'b0;
      hold_left    <= 0;
    end else begin
      if (ev_ch.valid && result_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: ev %0d cmd %0d seq %02h len %02h",
                     ev_ch.frame_event, ev_ch.command, ev_ch.frame_sequence,
                     ev_ch.frame_length);
        end else begin
          want = pending_results.pop_front();
          if (ev_ch.frame_event !== want.frame_event || ev_ch.command !== want.command ||
              ev_ch.frame_sequence !== want.frame_sequence ||
              ev_ch.frame_length !== want.frame_length) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result %0d: expected ev %0d cmd %0d seq %02h len %02h, ",
                        "got ev %0d cmd %0d seq %02h len %02h"},
                       results_seen, want.frame_event, want.command, want.frame_sequence,
                       want.frame_length, ev_ch.frame_event, ev_ch.command,
                       ev_ch.frame_sequence, ev_ch.frame_length);
          end
          event_tally[want.frame_event]++;
          if (want.frame_event == lfr_pkg::EV_GOOD) command_tally[want.command]++;
        end
      end
      // ready pattern: one long hold-off, calm stretches, random stalls
      if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        result_ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 500) begin
        long_hold_done = 1'b1;
        hold_left    <= LongHold - 1;
        result_ready <= 1'b0;
      end else if ((results_seen / 200) % 3 == 2) begin
        result_ready <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
          result_ready <= 1'b1;
        end else begin
          hold_left    <= (roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
          result_ready <= 1'b0;
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((byte_valid && rx_ch.ready) || (ev_ch.valid && result_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("timeout: no beat for %0d cycles, %0d results still due",
               quiet_cycles, pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    int                 pick;
    int                 len;
    logic [7:0]         frame_seq;
    logic [7:0]         p0;
    logic [7:0]         p1;
    logic [7:0]         p2;
    bit                 bad;
    bit                 mid_drain_done;
    lfr_pkg::command_e  cmd;

    // directed: confirm, stray bytes, zero length, confirm byte as data
    push_byte(lfr_pkg::ConfirmByte);
    push_byte(8'h00);
    push_byte(8'hFF);
    send_frame(8'h00, 0, 8'h00, 8'h00, 8'h00, 1'b0);
    send_frame(8'hFF, 0, 8'h00, 8'h00, 8'h00, 1'b1);
    send_frame(8'h5A, lfr_pkg::LenOne, lfr_pkg::ConfirmByte, 8'h00, 8'h00, 1'b0);
    send_frame(8'h01, lfr_pkg::LenOne, lfr_pkg::OpPlay, 8'h00, 8'h00, 1'b0);

    // random part starts once the directed results are all out
    drain_next = 1'b1;
    mid_drain_done = 1'b0;
    while (bytes_queued < ByteTarget) begin
      if (!mid_drain_done && bytes_queued >= 1200) begin
        drain_next = 1'b1;
        mid_drain_done = 1'b1;
      end
      pick      = $urandom_range(0, 99);
      frame_seq = 8'($urandom);
      bad       = ($urandom_range(0, 6) == 0);
      if (pick < 45) begin
        // well-formed command frame
        cmd = lfr_pkg::command_e'($urandom_range(1, 9));
        case (cmd)
          lfr_pkg::CMD_VERSION: send_frame(frame_seq, lfr_pkg::LenVersion, lfr_pkg::OpVersion,
                                           8'($urandom), 8'($urandom), bad);
          lfr_pkg::CMD_PLAY:    send_frame(frame_seq, lfr_pkg::LenOne, lfr_pkg::OpPlay,
                                           8'h00, 8'h00, bad);
          lfr_pkg::CMD_PAUSE:   send_frame(frame_seq, lfr_pkg::LenOne, lfr_pkg::OpPause,
                                           8'h00, 8'h00, bad);
          lfr_pkg::CMD_STANDBY: send_frame(frame_seq, lfr_pkg::LenOne, lfr_pkg::OpStandby,
                                           8'h00, 8'h00, bad);
          lfr_pkg::CMD_DISC:    send_frame(frame_seq, lfr_pkg::LenOne, lfr_pkg::OpDisc,
                                           8'h00, 8'h00, bad);
          lfr_pkg::CMD_NEXT:    send_frame(frame_seq, lfr_pkg::LenTwo, lfr_pkg::OpNext,
                                           lfr_pkg::ArgOne, 8'h00, bad);
          lfr_pkg::CMD_PREV:    send_frame(frame_seq, lfr_pkg::LenThree, lfr_pkg::OpPrev,
                                           lfr_pkg::ArgOne, lfr_pkg::ArgTwo, bad);
          lfr_pkg::CMD_ENTER:   send_frame(frame_seq, lfr_pkg::LenTwo, lfr_pkg::OpEnterExit,
                                           lfr_pkg::ArgEnter, 8'h00, bad);
          default:              send_frame(frame_seq, lfr_pkg::LenTwo, lfr_pkg::OpEnterExit,
                                           lfr_pkg::ArgExit, 8'h00, bad);
        endcase
      end else if (pick < 58) begin
        // short frame with command-like content, mostly near misses
        len = $urandom_range(0, 8);
        p0 = $urandom_range(0, 2) != 0 ? op_bytes[$urandom_range(0, 7)] : 8'($urandom);
        case ($urandom_range(0, 3))
          0:       p1 = lfr_pkg::ArgOne;
          1:       p1 = lfr_pkg::ArgEnter;
          2:       p1 = lfr_pkg::ArgExit;
          default: p1 = 8'($urandom);
        endcase
        p2 = $urandom_range(0, 1) ? lfr_pkg::ArgTwo : 8'($urandom);
        send_frame(frame_seq, len, p0, p1, p2, bad);
      end else if (pick < 64) begin
        // around the size limit and far beyond it
        len = $urandom_range(0, 1) ? $urandom_range(FrameLimit - 5, FrameLimit - 2)
                                   : $urandom_range(FrameLimit - 3, 255);
        send_frame(frame_seq, len, 8'($urandom), 8'($urandom), 8'($urandom), bad);
      end else if (pick < 72) begin
        push_byte(lfr_pkg::ConfirmByte);
      end else if (pick < 80) begin
        push_byte(8'($urandom));
      end else if (pick < 88) begin
        // broken frame: header and part of the payload only
        len = $urandom_range(1, 10);
        push_byte(lfr_pkg::StartByte);
        push_byte(frame_seq);
        push_byte(8'(len));
        repeat ($urandom_range(0, len)) push_byte(8'($urandom));
      end else begin
        send_frame(frame_seq, 0, 8'h00, 8'h00, 8'h00, bad);
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // every queued byte accepted and every result checked
    while (bytes_sent < bytes_queued || pending_results.size() > 0)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("run covered %0d bytes: %0d confirms, %0d good frames, %0d bad checksums",
             bytes_sent, event_tally[lfr_pkg::EV_CONFIRM], event_tally[lfr_pkg::EV_GOOD],
             event_tally[lfr_pkg::EV_BAD_SUM]);
    $display({"%0d drops; commands: none %0d ver %0d play %0d pause %0d stby %0d ",
              "disc %0d next %0d prev %0d enter %0d exit %0d"},
             event_tally[lfr_pkg::EV_DROPPED],
             command_tally[lfr_pkg::CMD_NONE], command_tally[lfr_pkg::CMD_VERSION],
             command_tally[lfr_pkg::CMD_PLAY], command_tally[lfr_pkg::CMD_PAUSE],
             command_tally[lfr_pkg::CMD_STANDBY], command_tally[lfr_pkg::CMD_DISC],
             command_tally[lfr_pkg::CMD_NEXT], command_tally[lfr_pkg::CMD_PREV],
             command_tally[lfr_pkg::CMD_ENTER], command_tally[lfr_pkg::CMD_EXIT]);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatching results", mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
